// ----- src/dqa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqa_pkg
// Types, constants and helpers shared by the DNS A-record response builder.
// ----------------------------------------------------------------------------
package dqa_pkg;

  localparam int MAX_ANSWERS  = 3;
  localparam int HEADER_BYTES = 12;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int REC_IDX_W    = 4;

  localparam logic [31:0] TTL_RESET = 32'd86400;

  // input item kinds
  localparam logic CMD_ADDR = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // header byte offsets
  localparam logic [HDR_IDX_W-1:0] HDR_FLAGS_HI   = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_FLAGS_LO   = HDR_IDX_W'(3);
  localparam logic [HDR_IDX_W-1:0] HDR_ANCOUNT_HI = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] HDR_ANCOUNT_LO = HDR_IDX_W'(7);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST       = HDR_IDX_W'(HEADER_BYTES - 1);

  localparam logic [7:0] QR_MASK    = 8'h80;
  localparam logic [7:0] RA_MASK    = 8'h80;
  localparam logic [7:0] FLAGS_KEEP = 8'hF0;
  localparam logic [3:0] RCODE_OK      = 4'd0;
  localparam logic [3:0] RCODE_NO_NAME = 4'd3;

  // answer record fields
  localparam logic [15:0] REC_PTR    = 16'hC00C;
  localparam logic [15:0] REC_TYPE_A = 16'h0001;
  localparam logic [15:0] REC_CLASS  = 16'h0001;
  localparam logic [15:0] REC_RDLEN  = 16'h0004;
  localparam logic [REC_IDX_W-1:0] REC_LAST = 4'd15;

  typedef struct packed {
    logic        cmd;
    logic [31:0] answer_address;
    logic [7:0]  packet_byte;
    logic [15:0] splice_offset;
    logic        packet_last;
  } dqa_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       response_end;
  } dqa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHORT,
    ST_HEAD,
    ST_BODY,
    ST_ANS
  } state_e;

  typedef enum logic [1:0] {
    RET_HEAD,
    RET_BODY,
    RET_END
  } ret_e;

  typedef enum logic [1:0] {
    SRC_RAW,
    SRC_EDIT,
    SRC_BYTE,
    SRC_ANS
  } src_e;

  typedef struct packed {
    logic emit;
    src_e src;
    logic run_end;
    logic resp_end;
    logic load;
    logic addr_wr;
    logic step;
    logic clear;
    logic idx_inc;
    logic ans_start;
    logic ans_inc;
  } dqa_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pos_short;
    logic pos_eleven;
    logic last;
    logic due;
    logic hdr_hit;
    logic body_hit;
    logic short_end;
    logic head_end;
    logic ans_end;
  } dqa_status_t;

  function automatic logic [7:0] rec_byte(input logic [REC_IDX_W-1:0] j,
                                          input logic [31:0] ttl,
                                          input logic [31:0] addr);
    logic [7:0] r;
    case (j)
      4'd0:    r = REC_PTR[15:8];
      4'd1:    r = REC_PTR[7:0];
      4'd2:    r = REC_TYPE_A[15:8];
      4'd3:    r = REC_TYPE_A[7:0];
      4'd4:    r = REC_CLASS[15:8];
      4'd5:    r = REC_CLASS[7:0];
      4'd6:    r = ttl[31:24];
      4'd7:    r = ttl[23:16];
      4'd8:    r = ttl[15:8];
      4'd9:    r = ttl[7:0];
      4'd10:   r = REC_RDLEN[15:8];
      4'd11:   r = REC_RDLEN[7:0];
      4'd12:   r = addr[31:24];
      4'd13:   r = addr[23:16];
      4'd14:   r = addr[15:8];
      default: r = addr[7:0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/dns_query_to_a_response.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_to_a_response
// Streams a DNS query in and an A-record response out, one byte per transaction.
// ----------------------------------------------------------------------------
// A query byte is taken in and then releases its response bytes: bytes before the
// twelfth release nothing (a short packet releases its bytes on its last one),
// the twelfth releases the edited 12-byte header, and each later byte releases
// itself. An answer burst releases 16 bytes per record. A new item is taken only
// once the previous byte has released all of its response bytes. The sequencer
// drives one output register, one byte per cycle while the output is not held back.
module dns_query_to_a_response #(
  parameter int MaxAnswers = dqa_pkg::MAX_ANSWERS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  dqa_pkg::dqa_in_t  in_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output dqa_pkg::dqa_out_t out_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [31:0]        cfg_data_i
);
  import dqa_pkg::*;

  dqa_cmd_t    cmd;
  dqa_status_t status;

  assign cfg_ready_o = 1'b1;

  dqa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_last_i  (in_i.packet_last),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  dqa_datapath #(
    .MaxAnswers (MaxAnswers)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ----- src/dqa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqa_ctrl
// Sequencer: walks short-packet release, header release, body bytes and answer record bursts.
// ----------------------------------------------------------------------------
module dqa_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_cmd_i,
  input  wire                  in_last_i,
  input  dqa_pkg::dqa_status_t status_i,
  output logic                 in_ready_o,
  output dqa_pkg::dqa_cmd_t    cmd_o
);
  import dqa_pkg::*;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_END;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_cmd_i == CMD_BYTE) begin
          if (status_i.pos_short) begin
            if (in_last_i) state_d = ST_SHORT;
          end else if (status_i.pos_eleven) begin
            state_d = ST_HEAD;
          end else begin
            state_d = ST_BODY;
          end
        end
      end
      ST_SHORT: begin
        if (status_i.slot_free && status_i.short_end) state_d = ST_IDLE;
      end
      ST_HEAD: begin
        if (status_i.hdr_hit) begin
          state_d = ST_ANS;
          ret_d   = RET_HEAD;
        end else if (status_i.slot_free && status_i.head_end) begin
          if (status_i.last && status_i.due) begin
            state_d = ST_ANS;
            ret_d   = RET_END;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_BODY: begin
        if (status_i.body_hit) begin
          state_d = ST_ANS;
          ret_d   = RET_BODY;
        end else if (status_i.slot_free) begin
          if (status_i.last && status_i.due) begin
            state_d = ST_ANS;
            ret_d   = RET_END;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ANS: begin
        if (status_i.slot_free && status_i.ans_end) begin
          case (ret_q)
            RET_HEAD: state_d = ST_HEAD;
            RET_BODY: state_d = ST_BODY;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.src  = SRC_RAW;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_ADDR) begin
            cmd_o.addr_wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            if (status_i.pos_short && !in_last_i) cmd_o.step = 1'b1;
          end
        end
      end
      ST_SHORT: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_RAW;
          if (status_i.short_end) begin
            cmd_o.run_end  = 1'b1;
            cmd_o.resp_end = 1'b1;
            cmd_o.clear    = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        if (status_i.hdr_hit) begin
          cmd_o.ans_start = 1'b1;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_EDIT;
          if (status_i.head_end) begin
            if (!(status_i.last && status_i.due)) begin
              cmd_o.run_end  = 1'b1;
              cmd_o.resp_end = status_i.last;
              cmd_o.clear    = status_i.last;
              cmd_o.step     = !status_i.last;
            end else begin
              cmd_o.ans_start = 1'b1;
            end
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_BODY: begin
        if (status_i.body_hit) begin
          cmd_o.ans_start = 1'b1;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_BYTE;
          if (!(status_i.last && status_i.due)) begin
            cmd_o.run_end  = 1'b1;
            cmd_o.resp_end = status_i.last;
            cmd_o.clear    = status_i.last;
            cmd_o.step     = !status_i.last;
          end else begin
            cmd_o.ans_start = 1'b1;
          end
        end
      end
      ST_ANS: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_ANS;
          if (status_i.ans_end) begin
            if (ret_q == RET_END) begin
              cmd_o.run_end  = 1'b1;
              cmd_o.resp_end = 1'b1;
              cmd_o.clear    = 1'b1;
            end
          end else begin
            cmd_o.ans_inc = 1'b1;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/dqa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dqa_datapath
// Answer table, header hold, packet position, record bytes and output register.
// ----------------------------------------------------------------------------
module dqa_datapath #(
  parameter int MaxAnswers = dqa_pkg::MAX_ANSWERS
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dqa_pkg::dqa_in_t     in_i,
  input  wire                  cfg_valid_i,
  input  wire [31:0]           cfg_data_i,
  input  wire                  out_ready_i,
  input  dqa_pkg::dqa_cmd_t    cmd_i,
  output dqa_pkg::dqa_status_t status_o,
  output logic                 out_valid_o,
  output dqa_pkg::dqa_out_t    out_o
);
  import dqa_pkg::*;

  localparam int CntW = $clog2(MaxAnswers + 1);

  logic [31:0]          ttl_q;
  logic [CntW-1:0]      count_q;
  logic [15:0]          pos_q;
  logic                 placed_q;
  logic [HDR_IDX_W-1:0] idx_q;
  logic [CntW-1:0]      ans_k_q;
  logic [REC_IDX_W-1:0] ans_j_q;
  logic                 last_q;
  logic                 out_valid_q;

  logic [31:0] table_q [MaxAnswers];
  logic [7:0]  hold_q  [HEADER_BYTES];
  logic [7:0]  byte_q;
  logic [15:0] splice_q;
  dqa_out_t    out_q;

  logic        table_wr;
  logic [7:0]  hold_sel;
  logic [7:0]  edit_byte;
  logic [31:0] addr_sel;
  logic [7:0]  byte_sel;
  logic [3:0]  rcode;
  logic [7:0]  ra_bits;

  assign table_wr = cmd_i.addr_wr && (pos_q == 16'd0) && (count_q < CntW'(MaxAnswers));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q       <= TTL_RESET;
      count_q     <= '0;
      pos_q       <= '0;
      placed_q    <= 1'b0;
      idx_q       <= '0;
      ans_k_q     <= '0;
      ans_j_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) ttl_q <= cfg_data_i;
      if (table_wr) count_q <= count_q + CntW'(1);
      if (cmd_i.load) begin
        idx_q  <= '0;
        last_q <= in_i.packet_last;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + HDR_IDX_W'(1);
      end
      if (cmd_i.ans_start) begin
        ans_k_q  <= '0;
        ans_j_q  <= '0;
        placed_q <= 1'b1;
      end else if (cmd_i.ans_inc) begin
        if (ans_j_q == REC_LAST) begin
          ans_j_q <= '0;
          ans_k_q <= ans_k_q + CntW'(1);
        end else begin
          ans_j_q <= ans_j_q + REC_IDX_W'(1);
        end
      end
      if (cmd_i.step && pos_q != 16'hFFFF) pos_q <= pos_q + 16'd1;
      if (cmd_i.clear) begin
        count_q  <= '0;
        pos_q    <= '0;
        placed_q <= 1'b0;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < MaxAnswers; e++) begin
      if (table_wr && count_q == CntW'(e)) table_q[e] <= in_i.answer_address;
    end
    if (cmd_i.load) begin
      byte_q   <= in_i.packet_byte;
      splice_q <= in_i.splice_offset;
      if (pos_q < 16'(HEADER_BYTES)) hold_q[pos_q[HDR_IDX_W-1:0]] <= in_i.packet_byte;
    end
    if (cmd_i.emit) begin
      out_q.out_byte     <= byte_sel;
      out_q.run_end      <= cmd_i.run_end;
      out_q.response_end <= cmd_i.resp_end;
    end
  end

  always_comb begin
    addr_sel = '0;
    for (int e = 0; e < MaxAnswers; e++) begin
      if (ans_k_q == CntW'(e)) addr_sel = table_q[e];
    end
  end

  assign hold_sel = hold_q[idx_q];
  assign rcode    = (count_q == '0) ? RCODE_NO_NAME : RCODE_OK;
  assign ra_bits  = hold_q[HDR_FLAGS_HI][0] ? RA_MASK : 8'h00;

  always_comb begin
    case (idx_q)
      HDR_FLAGS_HI:   edit_byte = hold_sel | QR_MASK;
      HDR_FLAGS_LO:   edit_byte = ((hold_sel | ra_bits) & FLAGS_KEEP) | {4'b0, rcode};
      HDR_ANCOUNT_HI: edit_byte = 8'h00;
      HDR_ANCOUNT_LO: edit_byte = 8'(count_q);
      default:        edit_byte = hold_sel;
    endcase
  end

  always_comb begin
    case (cmd_i.src)
      SRC_RAW:  byte_sel = hold_sel;
      SRC_EDIT: byte_sel = edit_byte;
      SRC_BYTE: byte_sel = byte_q;
      SRC_ANS:  byte_sel = rec_byte(ans_j_q, ttl_q, addr_sel);
      default:  byte_sel = byte_q;
    endcase
  end

  always_comb begin
    status_o.slot_free  = !out_valid_q || out_ready_i;
    status_o.pos_short  = pos_q < 16'(HEADER_BYTES - 1);
    status_o.pos_eleven = pos_q == 16'(HEADER_BYTES - 1);
    status_o.last       = last_q;
    status_o.due        = (count_q != '0) && !placed_q;
    status_o.hdr_hit    = status_o.due && (16'(idx_q) == splice_q);
    status_o.body_hit   = status_o.due && (pos_q == splice_q);
    status_o.short_end  = idx_q == pos_q[HDR_IDX_W-1:0];
    status_o.head_end   = idx_q == HDR_LAST;
    status_o.ans_end    = (ans_j_q == REC_LAST) && (ans_k_q == count_q - CntW'(1));
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ----- dv/tb_dns_query_to_a_response.sv -----
// ----------------------------------------------------------------------------
// tb_dns_query_to_a_response
// Self-checking bench for the DNS A-record response builder. Answer addresses
// and query bytes are streamed in with random idle gaps on both handshakes.
// A scoreboard predicts every response byte with its end flags and compares
// them in order. The answer TTL is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_dns_query_to_a_response;
  timeunit 1ns;
  timeprecision 1ps;

  import dqa_pkg::*;

  localparam int MAX_GAP      = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 45;

  class a_response_scoreboard;
    logic [31:0] ttl;
    logic [31:0] addr_table [MAX_ANSWERS];
    int          n_answers;
    logic [15:0] pos;
    logic [7:0]  hold [HEADER_BYTES];
    bit          placed;
    dqa_out_t    resp_q [$];
    int          errors;

    function new();
      ttl       = TTL_RESET;
      n_answers = 0;
      pos       = '0;
      placed    = 1'b0;
      errors    = 0;
      foreach (hold[i]) hold[i] = '0;
    endfunction

    function void set_ttl(logic [31:0] v);
      ttl = v;
    endfunction

    function int pending();
      return resp_q.size();
    endfunction

    function void add_byte(logic [7:0] b);
      dqa_out_t o;
      o.out_byte     = b;
      o.run_end      = 1'b0;
      o.response_end = 1'b0;
      resp_q.push_back(o);
    endfunction

    function void add_records();
      logic [127:0] rec;
      for (int k = 0; k < n_answers; k++) begin
        rec = {REC_PTR, REC_TYPE_A, REC_CLASS, ttl, REC_RDLEN, addr_table[k]};
        for (int j = 15; j >= 0; j--) add_byte(rec[j*8 +: 8]);
      end
      placed = 1'b1;
    endfunction

    function void add_at(logic [15:0] p, logic [7:0] b, logic [15:0] splice);
      if (n_answers > 0 && !placed && p == splice) add_records();
      add_byte(b);
    endfunction

    function void note_item(dqa_in_t it);
      logic [15:0] p;
      logic [7:0]  e;
      int          first;
      dqa_out_t    tail;
      first = resp_q.size();
      if (it.cmd == CMD_ADDR) begin
        if (pos == '0 && n_answers < MAX_ANSWERS) begin
          addr_table[n_answers] = it.answer_address;
          n_answers++;
        end
        return;
      end
      p = pos;
      if (p < HEADER_BYTES) hold[p] = it.packet_byte;
      if (p < HEADER_BYTES - 1) begin
        if (it.packet_last) begin
          for (int i = 0; i <= p; i++) add_byte(hold[i]);
        end
      end else if (p == HEADER_BYTES - 1) begin
        for (int i = 0; i < HEADER_BYTES; i++) begin
          e = hold[i];
          if (i == HDR_FLAGS_HI) begin
            e = e | QR_MASK;
          end else if (i == HDR_FLAGS_LO) begin
            e = ((e | (hold[HDR_FLAGS_HI][0] ? RA_MASK : 8'h00)) & FLAGS_KEEP)
                | {4'h0, (n_answers == 0) ? RCODE_NO_NAME : RCODE_OK};
          end else if (i == HDR_ANCOUNT_HI) begin
            e = 8'h00;
          end else if (i == HDR_ANCOUNT_LO) begin
            e = 8'(n_answers);
          end
          add_at(16'(i), e, it.splice_offset);
        end
      end else begin
        add_at(p, it.packet_byte, it.splice_offset);
      end
      if (it.packet_last) begin
        if (p >= HEADER_BYTES - 1 && n_answers > 0 && !placed) add_records();
      end
      if (resp_q.size() > first) begin
        tail              = resp_q[$];
        tail.run_end      = 1'b1;
        tail.response_end = it.packet_last;
        resp_q[resp_q.size() - 1] = tail;
      end
      if (it.packet_last) begin
        n_answers = 0;
        pos       = '0;
        placed    = 1'b0;
      end else if (pos != 16'hFFFF) begin
        pos++;
      end
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
      end
    endfunction

    function void check_byte(dqa_out_t got);
      dqa_out_t want;
      if (resp_q.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: response byte %h expected none", $time, got.out_byte);
        end
        return;
      end
      want = resp_q.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.run_end !== want.run_end) report("run_end", want.run_end, got.run_end);
      if (got.response_end !== want.response_end) begin
        report("response_end", want.response_end, got.response_end);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  dqa_in_t     in_item;
  logic        out_valid;
  logic        out_ready;
  dqa_out_t    out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  bit          idle_on = 1'b1;

  a_response_scoreboard sb = new();

  always #10 clk = ~clk;

  dns_query_to_a_response u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  task automatic push(input dqa_in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic send_address(input logic [31:0] a);
    dqa_in_t it;
    it.cmd            = CMD_ADDR;
    it.answer_address = a;
    it.packet_byte    = 8'($urandom);
    it.splice_offset  = 16'($urandom);
    it.packet_last    = 1'($urandom);
    push(it);
  endtask

  // noisy packets carry stray addresses mid-packet, always one before the second byte
  task automatic send_packet(input int len, input logic [15:0] splice, input int fill,
                             input bit noisy);
    dqa_in_t it;
    for (int k = 0; k < len; k++) begin
      if (noisy && k > 0 && (k == 1 || $urandom_range(0, 7) == 0)) send_address($urandom);
      it.cmd            = CMD_BYTE;
      it.answer_address = $urandom;
      it.packet_byte    = (fill < 0) ? 8'($urandom) : 8'(fill);
      it.splice_offset  = splice;
      it.packet_last    = (k == len - 1);
      push(it);
    end
  endtask

  task automatic random_packet(output int n_bytes);
    int          len;
    int          sel;
    int          n_addr;
    logic [15:0] splice;
    n_addr = $urandom_range(0, MAX_ANSWERS + 1);
    sel    = $urandom_range(0, 9);
    if (sel == 0) len = $urandom_range(1, HEADER_BYTES - 1);
    else if (sel == 1) len = $urandom_range(40, 80);
    else len = $urandom_range(HEADER_BYTES, 30);
    case ($urandom_range(0, 3))
      0:       splice = 16'($urandom_range(0, HEADER_BYTES - 1));
      1:       splice = 16'($urandom_range(len - 2, len + 2));
      2:       splice = 16'($urandom);
      default: splice = 16'($urandom_range(0, len - 1));
    endcase
    repeat (n_addr) begin
      if ($urandom_range(0, 3) == 0) begin
        send_address($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
      end else begin
        send_address($urandom);
      end
    end
    send_packet(len, splice, -1, $urandom_range(0, 3) == 0);
    n_bytes = len;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_ttl(v);
  endtask

  initial begin : sink
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_byte(out_item);
    end
  end

  initial begin : stimulus
    logic [31:0] ttl_plan [5];
    int          n_bytes;
    int          phase_bytes;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    ttl_plan  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0001, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short packet with stray addresses, then full table with splice inside the header
    send_packet(3, 16'h0000, 8'hFF, 1'b1);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address($urandom);
    send_address($urandom);
    send_packet(13, 16'd5, 8'hFF, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_ttl(ttl_plan[ph]);
      idle_on     = (ph != 2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_packet(n_bytes);
        phase_bytes += n_bytes;
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
